// ===== sv/fsc_pkg.sv =====
// Shared types, widths and helpers for the fuzzy steering controller.
// No dependencies; every other file refers to this package by scoped names.
package fsc_pkg;

    localparam int LAT_W     = 16;
    localparam int HEAD_W    = 17;
    localparam int STEER_W   = 15;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W     = 18;

    // Memberships are unsigned Q0.20; 1.0 needs a 21st bit
    localparam int MEM_FRAC = 20;
    localparam int MEM_W    = MEM_FRAC + 1;
    localparam logic [MEM_W-1:0] MEM_ONE = MEM_W'(1) << MEM_FRAC;

    // Shared divider and multiplier widths
    localparam int DIV_W     = 22;
    localparam int DIV_LOW_W = 20;
    localparam int DIV_CNT_W = 5;
    localparam int MUL_A_W   = 21;
    localparam int MUL_B_W   = 22;
    localparam int PROD_W    = 43;
    localparam int ACC_W     = 58;
    localparam int HI_SHIFT  = 21;
    localparam int OPP_STEPS = 16;

    // Smoothing window; must stay a power of two
    localparam int AVG_TAPS  = 4;
    localparam int AVG_SHIFT = $clog2(AVG_TAPS);
    localparam int SUM_W     = STEER_W + AVG_SHIFT + 1;

    localparam logic signed [RAW_W-1:0] CMD_MAX = RAW_W'(16383);
    localparam logic signed [RAW_W-1:0] CMD_MIN = -RAW_W'(16384);

    typedef enum logic [2:0] {
        CFG_LAT_LEFT   = 3'd0,
        CFG_LAT_CENTER = 3'd1,
        CFG_LAT_RIGHT  = 3'd2,
        CFG_HEAD_LEFT  = 3'd3,
        CFG_HEAD_CENTER= 3'd4,
        CFG_HEAD_RIGHT = 3'd5,
        CFG_STEER_RIGHT= 3'd6,
        CFG_STEER_LEFT = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_LAT_GO, S_LAT_WAIT, S_HEAD_GO, S_HEAD_WAIT, S_RULE,
        S_PULL_MUL, S_PULL_RND,
        S_SQ_A, S_HI_A, S_LO_A, S_SQ_B, S_HI_B, S_LO_B, S_ACC_END,
        S_MAG, S_OPP_GO, S_OPP_WAIT, S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        RULE_PULL_R, RULE_OPP_A, RULE_OPP_B, RULE_PULL_L,
        RULE_FULL_R, RULE_FULL_L, RULE_NONE
    } t_rule;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_CLEAR, ACC_ADD, ACC_ADD_HI
    } t_acc_op;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem;
        logic [DIV_LOW_W-1:0] low;
        logic [DIV_W-1:0]     den;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                      mul_en;
        logic [MUL_A_W-1:0]        a;
        logic signed [MUL_B_W-1:0] b;
        t_acc_op                   op;
    } t_mac_cmd;

    function automatic logic signed [STEER_W-1:0] sat_steer(
        input logic signed [RAW_W-1:0] v);
        logic signed [STEER_W-1:0] r;
        if (v > CMD_MAX) begin
            r = STEER_W'(CMD_MAX);
        end else if (v < CMD_MIN) begin
            r = STEER_W'(CMD_MIN);
        end else begin
            r = STEER_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== sv/fuzzy_steering_controller_top.sv =====
// Top level of the fuzzy steering controller: registers, sequencer, datapath.
// Depends on fsc_pkg, fsc_div and fsc_mac.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready   | i_lateral_error, i_heading_error
//  output   | o_out_valid / i_out_ready | o_raw_steering, o_smoothed_steering
//  config   | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// Two 20-step membership divisions and a 16-step weight division all run on
// the single shared divider, one quotient bit per cycle; the weight division
// is skipped when the weight sum is zero.
// Reset is synchronous, active low; it restores the breakpoints and limits
// and clears the smoothing history. o_in_ready is high only between items.
// A finished result waits in the output register; the next item can be
// taken meanwhile, and only the next result waits for that register to drain.
module fuzzy_steering_controller_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [fsc_pkg::LAT_W-1:0]      i_lateral_error,
    input  logic signed [fsc_pkg::HEAD_W-1:0]     i_heading_error,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [fsc_pkg::STEER_W-1:0]    o_raw_steering,
    output logic signed [fsc_pkg::STEER_W-1:0]    o_smoothed_steering,
    input  logic                                  i_cfg_we,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fsc_pkg::CFG_W-1:0]             i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic signed [fsc_pkg::LAT_W-1:0]   r_l1, r_l2, r_l3;
    logic signed [fsc_pkg::HEAD_W-1:0]  r_h1, r_h2, r_h3;
    logic signed [fsc_pkg::STEER_W-1:0] r_rlim, r_llim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1   <= -fsc_pkg::LAT_W'(384);
            r_l2   <= '0;
            r_l3   <= fsc_pkg::LAT_W'(384);
            r_h1   <= -fsc_pkg::HEAD_W'(5120);
            r_h2   <= '0;
            r_h3   <= fsc_pkg::HEAD_W'(5120);
            r_rlim <= fsc_pkg::STEER_W'(8640);
            r_llim <= -fsc_pkg::STEER_W'(8640);
        end else if (i_cfg_we) begin
            unique case (fsc_pkg::t_cfg_idx'(i_cfg_index))
                fsc_pkg::CFG_LAT_LEFT:    r_l1   <= i_cfg_data[fsc_pkg::LAT_W-1:0];
                fsc_pkg::CFG_LAT_CENTER:  r_l2   <= i_cfg_data[fsc_pkg::LAT_W-1:0];
                fsc_pkg::CFG_LAT_RIGHT:   r_l3   <= i_cfg_data[fsc_pkg::LAT_W-1:0];
                fsc_pkg::CFG_HEAD_LEFT:   r_h1   <= i_cfg_data;
                fsc_pkg::CFG_HEAD_CENTER: r_h2   <= i_cfg_data;
                fsc_pkg::CFG_HEAD_RIGHT:  r_h3   <= i_cfg_data;
                fsc_pkg::CFG_STEER_RIGHT: r_rlim <= i_cfg_data[fsc_pkg::STEER_W-1:0];
                fsc_pkg::CFG_STEER_LEFT:  r_llim <= i_cfg_data[fsc_pkg::STEER_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- state and datapath registers ----------------
    fsc_pkg::t_state r_state, n_state;

    logic signed [fsc_pkg::LAT_W-1:0]    r_lat;
    logic signed [fsc_pkg::HEAD_W-1:0]   r_head;
    logic [fsc_pkg::DIV_LOW_W-1:0]       r_q_lat, r_q_head;
    logic [fsc_pkg::MUL_A_W-1:0]         r_sq_lo;
    logic [fsc_pkg::ACC_W-2:0]           r_mag;
    logic                                r_neg;
    logic [fsc_pkg::DIV_W-1:0]           r_wsum;
    logic signed [fsc_pkg::STEER_W-1:0]  r_raw;
    logic signed [fsc_pkg::STEER_W-1:0]  r_hist [fsc_pkg::AVG_TAPS-1];
    logic                                r_out_valid;
    logic signed [fsc_pkg::STEER_W-1:0]  r_out_raw, r_out_smooth;

    fsc_pkg::t_div_req                   w_div_req;
    logic                                w_div_busy;
    logic [fsc_pkg::DIV_LOW_W-1:0]       w_div_quot;
    fsc_pkg::t_mac_cmd                   w_mac_cmd;
    logic signed [fsc_pkg::PROD_W-1:0]   w_prod;
    logic signed [fsc_pkg::ACC_W-1:0]    w_acc;

    logic w_in_xfer, w_can_load;

    fsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    fsc_mac u_mac (
        .i_clk  (i_clk),
        .i_cmd  (w_mac_cmd),
        .o_prod (w_prod),
        .o_acc  (w_acc)
    );

    // ---------------- fuzzification ----------------
    // Region flags per axis; at most one division is meaningful per axis.
    // A value at or below the left point has no right membership at all.
    logic lat_le1, lat_le2, lat_lt2, lat_lt3, lat_div_lo, lat_div_hi, lat_full_hi;
    logic hd_le1, hd_le2, hd_lt2, hd_lt3, hd_div_lo, hd_div_hi, hd_full_hi;

    assign lat_le1     = r_lat <= r_l1;
    assign lat_le2     = r_lat <= r_l2;
    assign lat_lt2     = r_lat <  r_l2;
    assign lat_lt3     = r_lat <  r_l3;
    assign lat_div_lo  = !lat_le1 && lat_le2;
    assign lat_div_hi  = !lat_le1 && !lat_le2 && lat_lt3;
    assign lat_full_hi = !lat_le1 && !lat_le2 && !lat_lt3;

    assign hd_le1      = r_head <= r_h1;
    assign hd_le2      = r_head <= r_h2;
    assign hd_lt2      = r_head <  r_h2;
    assign hd_lt3      = r_head <  r_h3;
    assign hd_div_lo   = !hd_le1 && hd_le2;
    assign hd_div_hi   = !hd_le1 && !hd_le2 && hd_lt3;
    assign hd_full_hi  = !hd_le1 && !hd_le2 && !hd_lt3;

    // Distances and spans; the ones picked by the flags are not negative
    logic signed [fsc_pkg::LAT_W:0]  lat_d_lo, lat_d_hi, lat_s_lo, lat_s_hi;
    logic signed [fsc_pkg::HEAD_W:0] hd_d_lo, hd_d_hi, hd_s_lo, hd_s_hi;

    assign lat_d_lo = (fsc_pkg::LAT_W+1)'(r_l2) - (fsc_pkg::LAT_W+1)'(r_lat);
    assign lat_d_hi = (fsc_pkg::LAT_W+1)'(r_lat) - (fsc_pkg::LAT_W+1)'(r_l2);
    assign lat_s_lo = (fsc_pkg::LAT_W+1)'(r_l2) - (fsc_pkg::LAT_W+1)'(r_l1);
    assign lat_s_hi = (fsc_pkg::LAT_W+1)'(r_l3) - (fsc_pkg::LAT_W+1)'(r_l2);
    assign hd_d_lo  = (fsc_pkg::HEAD_W+1)'(r_h2) - (fsc_pkg::HEAD_W+1)'(r_head);
    assign hd_d_hi  = (fsc_pkg::HEAD_W+1)'(r_head) - (fsc_pkg::HEAD_W+1)'(r_h2);
    assign hd_s_lo  = (fsc_pkg::HEAD_W+1)'(r_h2) - (fsc_pkg::HEAD_W+1)'(r_h1);
    assign hd_s_hi  = (fsc_pkg::HEAD_W+1)'(r_h3) - (fsc_pkg::HEAD_W+1)'(r_h2);

    logic [fsc_pkg::MEM_W-1:0] ml_lo, ml_hi, mh_lo, mh_hi;

    assign ml_lo = lat_le1    ? fsc_pkg::MEM_ONE :
                   lat_div_lo ? {1'b0, r_q_lat} : '0;
    assign ml_hi = lat_full_hi ? fsc_pkg::MEM_ONE :
                   lat_div_hi  ? {1'b0, r_q_lat} : '0;
    assign mh_lo = hd_le1    ? fsc_pkg::MEM_ONE :
                   hd_div_lo ? {1'b0, r_q_head} : '0;
    assign mh_hi = hd_full_hi ? fsc_pkg::MEM_ONE :
                   hd_div_hi  ? {1'b0, r_q_head} : '0;

    // ---------------- rule base ----------------
    fsc_pkg::t_rule w_rule;

    always_comb begin
        priority if (!lat_le1 && lat_le2 && !hd_le1 && hd_le2) begin
            w_rule = fsc_pkg::RULE_PULL_R;
        end else if (lat_lt2 && !hd_le2) begin
            w_rule = fsc_pkg::RULE_OPP_A;
        end else if (!lat_le2 && hd_lt2) begin
            w_rule = fsc_pkg::RULE_OPP_B;
        end else if (!lat_lt2 && lat_lt3 && !hd_lt2 && hd_lt3) begin
            w_rule = fsc_pkg::RULE_PULL_L;
        end else if (lat_le1 || hd_le1) begin
            w_rule = fsc_pkg::RULE_FULL_R;
        end else if (!lat_lt3 || !hd_lt3) begin
            w_rule = fsc_pkg::RULE_FULL_L;
        end else begin
            w_rule = fsc_pkg::RULE_NONE;
        end
    end

    // Single pull: the extreme product is the extreme membership, flipped by sign
    logic [fsc_pkg::MEM_W-1:0]          pull_m;
    logic signed [fsc_pkg::STEER_W-1:0] pull_v;
    logic                               pull_big;

    always_comb begin
        if (w_rule == fsc_pkg::RULE_PULL_R) begin
            pull_v   = r_rlim;
            pull_big = !r_rlim[fsc_pkg::STEER_W-1];
            pull_m   = ((ml_lo > mh_lo) == pull_big) ? ml_lo : mh_lo;
        end else begin
            pull_v   = r_llim;
            pull_big = r_llim[fsc_pkg::STEER_W-1];
            pull_m   = ((ml_hi > mh_hi) == pull_big) ? ml_hi : mh_hi;
        end
    end

    // Opposing pulls
    logic [fsc_pkg::MEM_W-1:0]          opp_ma, opp_mb;
    logic signed [fsc_pkg::STEER_W-1:0] opp_va, opp_vb;

    assign opp_ma = (w_rule == fsc_pkg::RULE_OPP_A) ? ml_lo  : ml_hi;
    assign opp_va = (w_rule == fsc_pkg::RULE_OPP_A) ? r_rlim : r_llim;
    assign opp_mb = (w_rule == fsc_pkg::RULE_OPP_A) ? mh_hi  : mh_lo;
    assign opp_vb = (w_rule == fsc_pkg::RULE_OPP_A) ? r_llim : r_rlim;

    // ---------------- rounding helpers ----------------
    // Pull product / 2^20, rounded half away from zero
    logic [fsc_pkg::PROD_W-1:0]        pull_mag;
    logic [fsc_pkg::PROD_W-1:0]        pull_rnd;
    logic signed [fsc_pkg::RAW_W-1:0]  pull_raw;

    assign pull_mag = w_prod[fsc_pkg::PROD_W-1] ? fsc_pkg::PROD_W'(-w_prod)
                                                : fsc_pkg::PROD_W'(w_prod);
    assign pull_rnd = (pull_mag + (fsc_pkg::PROD_W'(1) << (fsc_pkg::MEM_FRAC - 1)))
                      >> fsc_pkg::MEM_FRAC;
    assign pull_raw = w_prod[fsc_pkg::PROD_W-1] ? -fsc_pkg::RAW_W'(pull_rnd)
                                                : fsc_pkg::RAW_W'(pull_rnd);

    // Weighted sum magnitude plus half the divisor, scaled down by 2^20
    logic [fsc_pkg::ACC_W-1:0]  opp_num;
    logic [fsc_pkg::ACC_W-1:0]  opp_scaled;
    assign opp_num    = {1'b0, r_mag} +
                        (fsc_pkg::ACC_W'(r_wsum) << (fsc_pkg::MEM_FRAC - 1));
    assign opp_scaled = opp_num >> fsc_pkg::MEM_FRAC;

    logic signed [fsc_pkg::RAW_W-1:0] opp_raw;
    assign opp_raw = r_neg ? -fsc_pkg::RAW_W'(w_div_quot[fsc_pkg::OPP_STEPS-1:0])
                           :  fsc_pkg::RAW_W'(w_div_quot[fsc_pkg::OPP_STEPS-1:0]);

    // ---------------- smoothing ----------------
    logic signed [fsc_pkg::SUM_W-1:0]  sm_sum;
    logic [fsc_pkg::SUM_W-1:0]         sm_mag, sm_rnd;
    logic signed [fsc_pkg::RAW_W-1:0]  sm_val;

    always_comb begin
        sm_sum = fsc_pkg::SUM_W'(r_raw);
        for (int k = 0; k < fsc_pkg::AVG_TAPS - 1; k++) begin
            sm_sum = sm_sum + fsc_pkg::SUM_W'(r_hist[k]);
        end
    end

    assign sm_mag = sm_sum[fsc_pkg::SUM_W-1] ? fsc_pkg::SUM_W'(-sm_sum)
                                             : fsc_pkg::SUM_W'(sm_sum);
    assign sm_rnd = (sm_mag + fsc_pkg::SUM_W'(fsc_pkg::AVG_TAPS / 2)) >> fsc_pkg::AVG_SHIFT;
    assign sm_val = sm_sum[fsc_pkg::SUM_W-1] ? -fsc_pkg::RAW_W'(sm_rnd)
                                             :  fsc_pkg::RAW_W'(sm_rnd);

    // ---------------- handshakes ----------------
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_can_load = !r_out_valid || i_out_ready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsc_pkg::S_IDLE:      if (w_in_xfer) n_state = fsc_pkg::S_LAT_GO;
            fsc_pkg::S_LAT_GO:    n_state = fsc_pkg::S_LAT_WAIT;
            fsc_pkg::S_LAT_WAIT:  if (!w_div_busy) n_state = fsc_pkg::S_HEAD_GO;
            fsc_pkg::S_HEAD_GO:   n_state = fsc_pkg::S_HEAD_WAIT;
            fsc_pkg::S_HEAD_WAIT: if (!w_div_busy) n_state = fsc_pkg::S_RULE;
            fsc_pkg::S_RULE: begin
                unique case (w_rule)
                    fsc_pkg::RULE_PULL_R,
                    fsc_pkg::RULE_PULL_L: n_state = fsc_pkg::S_PULL_MUL;
                    fsc_pkg::RULE_OPP_A,
                    fsc_pkg::RULE_OPP_B:  n_state = fsc_pkg::S_SQ_A;
                    default:              n_state = fsc_pkg::S_FINISH;
                endcase
            end
            fsc_pkg::S_PULL_MUL:  n_state = fsc_pkg::S_PULL_RND;
            fsc_pkg::S_PULL_RND:  n_state = fsc_pkg::S_FINISH;
            fsc_pkg::S_SQ_A:      n_state = fsc_pkg::S_HI_A;
            fsc_pkg::S_HI_A:      n_state = fsc_pkg::S_LO_A;
            fsc_pkg::S_LO_A:      n_state = fsc_pkg::S_SQ_B;
            fsc_pkg::S_SQ_B:      n_state = fsc_pkg::S_HI_B;
            fsc_pkg::S_HI_B:      n_state = fsc_pkg::S_LO_B;
            fsc_pkg::S_LO_B:      n_state = fsc_pkg::S_ACC_END;
            fsc_pkg::S_ACC_END:   n_state = fsc_pkg::S_MAG;
            fsc_pkg::S_MAG:       n_state = fsc_pkg::S_OPP_GO;
            fsc_pkg::S_OPP_GO:    n_state = (r_wsum == '0) ? fsc_pkg::S_FINISH
                                                           : fsc_pkg::S_OPP_WAIT;
            fsc_pkg::S_OPP_WAIT:  if (!w_div_busy) n_state = fsc_pkg::S_FINISH;
            fsc_pkg::S_FINISH:    if (w_can_load) n_state = fsc_pkg::S_IDLE;
            default:              n_state = fsc_pkg::S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        o_in_ready       = (r_state == fsc_pkg::S_IDLE);
        w_div_req        = '0;
        w_mac_cmd.mul_en = 1'b0;
        w_mac_cmd.a      = '0;
        w_mac_cmd.b      = '0;
        w_mac_cmd.op     = fsc_pkg::ACC_HOLD;
        unique case (r_state)
            fsc_pkg::S_LAT_GO: begin
                w_div_req.start = 1'b1;
                w_div_req.steps = fsc_pkg::DIV_CNT_W'(fsc_pkg::MEM_FRAC);
                w_div_req.rem   = fsc_pkg::DIV_W'(unsigned'(lat_div_lo ? lat_d_lo : lat_d_hi));
                w_div_req.den   = fsc_pkg::DIV_W'(unsigned'(lat_div_lo ? lat_s_lo : lat_s_hi));
            end
            fsc_pkg::S_HEAD_GO: begin
                w_div_req.start = 1'b1;
                w_div_req.steps = fsc_pkg::DIV_CNT_W'(fsc_pkg::MEM_FRAC);
                w_div_req.rem   = fsc_pkg::DIV_W'(unsigned'(hd_div_lo ? hd_d_lo : hd_d_hi));
                w_div_req.den   = fsc_pkg::DIV_W'(unsigned'(hd_div_lo ? hd_s_lo : hd_s_hi));
            end
            fsc_pkg::S_OPP_GO: begin
                // quotient fits 16 bits, so the top part already sits below the divisor
                w_div_req.start = (r_wsum != '0);
                w_div_req.steps = fsc_pkg::DIV_CNT_W'(fsc_pkg::OPP_STEPS);
                w_div_req.rem   = fsc_pkg::DIV_W'(opp_scaled >> fsc_pkg::OPP_STEPS);
                w_div_req.low   = {opp_scaled[fsc_pkg::OPP_STEPS-1:0],
                                   (fsc_pkg::DIV_LOW_W - fsc_pkg::OPP_STEPS)'(0)};
                w_div_req.den   = r_wsum;
            end
            fsc_pkg::S_PULL_MUL: begin
                w_mac_cmd.mul_en = 1'b1;
                w_mac_cmd.a      = pull_m;
                w_mac_cmd.b      = fsc_pkg::MUL_B_W'(pull_v);
            end
            fsc_pkg::S_SQ_A: begin
                w_mac_cmd.mul_en = 1'b1;
                w_mac_cmd.a      = opp_ma;
                w_mac_cmd.b      = signed'({1'b0, opp_ma});
                w_mac_cmd.op     = fsc_pkg::ACC_CLEAR;
            end
            fsc_pkg::S_HI_A: begin
                w_mac_cmd.mul_en = 1'b1;
                w_mac_cmd.a      = w_prod[2*fsc_pkg::HI_SHIFT-1:fsc_pkg::HI_SHIFT];
                w_mac_cmd.b      = fsc_pkg::MUL_B_W'(opp_va);
            end
            fsc_pkg::S_LO_A: begin
                w_mac_cmd.mul_en = 1'b1;
                w_mac_cmd.a      = r_sq_lo;
                w_mac_cmd.b      = fsc_pkg::MUL_B_W'(opp_va);
                w_mac_cmd.op     = fsc_pkg::ACC_ADD_HI;
            end
            fsc_pkg::S_SQ_B: begin
                w_mac_cmd.mul_en = 1'b1;
                w_mac_cmd.a      = opp_mb;
                w_mac_cmd.b      = signed'({1'b0, opp_mb});
                w_mac_cmd.op     = fsc_pkg::ACC_ADD;
            end
            fsc_pkg::S_HI_B: begin
                w_mac_cmd.mul_en = 1'b1;
                w_mac_cmd.a      = w_prod[2*fsc_pkg::HI_SHIFT-1:fsc_pkg::HI_SHIFT];
                w_mac_cmd.b      = fsc_pkg::MUL_B_W'(opp_vb);
            end
            fsc_pkg::S_LO_B: begin
                w_mac_cmd.mul_en = 1'b1;
                w_mac_cmd.a      = r_sq_lo;
                w_mac_cmd.b      = fsc_pkg::MUL_B_W'(opp_vb);
                w_mac_cmd.op     = fsc_pkg::ACC_ADD_HI;
            end
            fsc_pkg::S_ACC_END: w_mac_cmd.op = fsc_pkg::ACC_ADD;
            default: ;
        endcase
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fsc_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    r_lat  <= i_lateral_error;
                    r_head <= i_heading_error;
                end
            end
            fsc_pkg::S_LAT_WAIT:  if (!w_div_busy) r_q_lat  <= w_div_quot;
            fsc_pkg::S_HEAD_WAIT: if (!w_div_busy) r_q_head <= w_div_quot;
            fsc_pkg::S_RULE: begin
                unique case (w_rule)
                    fsc_pkg::RULE_FULL_R: r_raw <= r_rlim;
                    fsc_pkg::RULE_FULL_L: r_raw <= r_llim;
                    fsc_pkg::RULE_NONE:   r_raw <= '0;
                    default: ;
                endcase
            end
            fsc_pkg::S_PULL_RND: r_raw <= fsc_pkg::sat_steer(pull_raw);
            // keep the low half of the square for the second partial product
            fsc_pkg::S_HI_A,
            fsc_pkg::S_HI_B:     r_sq_lo <= w_prod[fsc_pkg::HI_SHIFT-1:0];
            fsc_pkg::S_MAG: begin
                r_neg  <= w_acc[fsc_pkg::ACC_W-1];
                r_mag  <= w_acc[fsc_pkg::ACC_W-1] ? (fsc_pkg::ACC_W-1)'(-w_acc)
                                                  : (fsc_pkg::ACC_W-1)'(w_acc);
                r_wsum <= fsc_pkg::DIV_W'(opp_ma) + fsc_pkg::DIV_W'(opp_mb);
            end
            // zero weight sum: no pull at all
            fsc_pkg::S_OPP_GO:   if (r_wsum == '0) r_raw <= '0;
            fsc_pkg::S_OPP_WAIT: if (!w_div_busy) r_raw <= fsc_pkg::sat_steer(opp_raw);
            default: ;
        endcase
    end

    // ---------------- control, history and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < fsc_pkg::AVG_TAPS - 1; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == fsc_pkg::S_FINISH && w_can_load) begin
                r_out_valid <= 1'b1;
                // advance the history, newest first
                r_hist[0] <= r_raw;
                for (int k = 1; k < fsc_pkg::AVG_TAPS - 1; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fsc_pkg::S_FINISH && w_can_load) begin
            r_out_raw    <= r_raw;
            r_out_smooth <= fsc_pkg::sat_steer(sm_val);
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_raw_steering      = r_out_raw;
    assign o_smoothed_steering = r_out_smooth;

endmodule

// ===== sv/fsc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Uses fsc_pkg for the request struct and widths.
module fsc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fsc_pkg::t_div_req               i_req,
    output logic                            o_busy,
    output logic [fsc_pkg::DIV_LOW_W-1:0]   o_quot
);

    logic                             r_busy;
    logic [fsc_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [fsc_pkg::DIV_W-1:0]        r_rem;
    logic [fsc_pkg::DIV_W-1:0]        r_den;
    logic [fsc_pkg::DIV_LOW_W-1:0]    r_sh;
    logic [fsc_pkg::DIV_W:0]          w_shift;
    logic [fsc_pkg::DIV_W:0]          w_trial;

    assign w_shift = {r_rem, r_sh[fsc_pkg::DIV_LOW_W-1]};
    assign w_trial = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == fsc_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_den <= i_req.den;
            r_sh  <= i_req.low;
        end else if (r_busy) begin
            // keep the shifted remainder when the trial goes negative
            if (!w_trial[fsc_pkg::DIV_W]) begin
                r_rem <= w_trial[fsc_pkg::DIV_W-1:0];
            end else begin
                r_rem <= w_shift[fsc_pkg::DIV_W-1:0];
            end
            r_sh <= {r_sh[fsc_pkg::DIV_LOW_W-2:0], ~w_trial[fsc_pkg::DIV_W]};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_sh;

endmodule

// ===== sv/fsc_mac.sv =====
// Shared multiplier with a registered product and a wide accumulator.
// Uses fsc_pkg for the command struct and widths.
module fsc_mac (
    input  logic                                i_clk,
    input  fsc_pkg::t_mac_cmd                   i_cmd,
    output logic signed [fsc_pkg::PROD_W-1:0]   o_prod,
    output logic signed [fsc_pkg::ACC_W-1:0]    o_acc
);

    logic signed [fsc_pkg::PROD_W-1:0]          r_prod;
    logic signed [fsc_pkg::ACC_W-1:0]           r_acc;
    logic signed [fsc_pkg::MUL_B_W+fsc_pkg::MUL_A_W:0] w_full;
    logic signed [fsc_pkg::ACC_W-1:0]           w_ext;

    assign w_full = $signed({1'b0, i_cmd.a}) * i_cmd.b;
    assign w_ext  = fsc_pkg::ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_full[fsc_pkg::PROD_W-1:0];
        end
        unique case (i_cmd.op)
            fsc_pkg::ACC_CLEAR:  r_acc <= '0;
            fsc_pkg::ACC_ADD:    r_acc <= r_acc + w_ext;
            fsc_pkg::ACC_ADD_HI: r_acc <= r_acc + (w_ext <<< fsc_pkg::HI_SHIFT);
            default:             r_acc <= r_acc;
        endcase
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ===== sv/fsc_checker.sv =====
// Port-level checks for the fuzzy steering controller, bound to the top.
// Depends on fsc_pkg and fuzzy_steering_controller_top.
module fsc_port_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [fsc_pkg::STEER_W-1:0]  o_raw_steering,
    input logic signed [fsc_pkg::STEER_W-1:0]  o_smoothed_steering
);

    // reset leaves the block empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    // one item at a time: a transfer in drops ready
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held after input transfer");

    // a result cannot appear without an item in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !(i_in_valid && o_in_ready) && !o_out_valid |=> !o_out_valid)
        else $error("result without input");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_raw_steering)
            && $stable(o_smoothed_steering))
        else $error("stalled result changed");

endmodule

bind fuzzy_steering_controller_top fsc_port_checker u_fsc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_raw_steering      (o_raw_steering),
    .o_smoothed_steering (o_smoothed_steering)
);

// ===== tb/fsc_checker.sv =====
// Checker for the fuzzy steering controller: watches the input, output and
// config channels, predicts each steering result and compares it field by field. Depends on fsc_pkg.
module fsc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic signed [fsc_pkg::LAT_W-1:0]   i_lateral_error,
    input  logic signed [fsc_pkg::HEAD_W-1:0]  i_heading_error,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [fsc_pkg::STEER_W-1:0] i_raw_steering,
    input  logic signed [fsc_pkg::STEER_W-1:0] i_smoothed_steering,
    input  logic                               i_cfg_we,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsc_pkg::CFG_W-1:0]          i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam longint ONE = longint'(1) << fsc_pkg::MEM_FRAC;

    typedef struct {
        logic signed [fsc_pkg::STEER_W-1:0] raw;
        logic signed [fsc_pkg::STEER_W-1:0] smooth;
    } t_steer;

    longint bp_lat [3];
    longint bp_head [3];
    longint lim_right, lim_left;
    longint raw_hist [fsc_pkg::AVG_TAPS-1];
    t_steer steer_q [$];

    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clamp_cmd(longint v);
        if (v > 16383) return 16383;
        if (v < -16384) return -16384;
        return v;
    endfunction

    task automatic membership(input longint x, input longint p1, input longint p2,
                              input longint p3, output longint lo, output longint hi);
        lo = 0;
        hi = 0;
        if (x <= p1) lo = ONE;
        else if (x <= p2) lo = (p2 - x) * ONE / (p2 - p1);
        else if (x < p3) hi = (x - p2) * ONE / (p3 - p2);
        else hi = ONE;
    endtask

    function automatic longint blend(longint ma, longint va, longint mb, longint vb);
        longint den;
        den = (ma + mb) * ONE;
        if (den == 0) return 0;
        return round_div(ma * ma * va + mb * mb * vb, den);
    endfunction

    // Work out the steering result of one transfer and advance the history
    task automatic predict_steer(input longint lat, input longint head);
        longint l1, l2, l3, h1, h2, h3, ll, lh, hl, hh, a, b, raw, sum;
        t_steer r;
        l1 = bp_lat[0]; l2 = bp_lat[1]; l3 = bp_lat[2];
        h1 = bp_head[0]; h2 = bp_head[1]; h3 = bp_head[2];
        membership(lat, l1, l2, l3, ll, lh);
        membership(head, h1, h2, h3, hl, hh);
        if (lat > l1 && lat <= l2 && head > h1 && head <= h2) begin
            a = ll * lim_right; b = hl * lim_right;
            raw = round_div(a > b ? a : b, ONE);
        end else if (lat < l2 && head > h2) begin
            raw = blend(ll, lim_right, hh, lim_left);
        end else if (lat > l2 && head < h2) begin
            raw = blend(lh, lim_left, hl, lim_right);
        end else if (lat >= l2 && lat < l3 && head >= h2 && head < h3) begin
            a = lh * lim_left; b = hh * lim_left;
            raw = round_div(a < b ? a : b, ONE);
        end else if (lat <= l1 || head <= h1) begin
            raw = lim_right;
        end else if (lat >= l3 || head >= h3) begin
            raw = lim_left;
        end else begin
            raw = 0;
        end
        raw = clamp_cmd(raw);
        sum = raw;
        foreach (raw_hist[i]) sum += raw_hist[i];
        for (int i = fsc_pkg::AVG_TAPS - 2; i > 0; i--) raw_hist[i] = raw_hist[i-1];
        raw_hist[0] = raw;
        r.raw = fsc_pkg::STEER_W'(raw);
        r.smooth = fsc_pkg::STEER_W'(clamp_cmd(round_div(sum, fsc_pkg::AVG_TAPS)));
        steer_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_steer exp_r;
        if (!i_rst_n) begin
            bp_lat[0] = -384; bp_lat[1] = 0; bp_lat[2] = 384;
            bp_head[0] = -5120; bp_head[1] = 0; bp_head[2] = 5120;
            lim_right = 8640; lim_left = -8640;
            foreach (raw_hist[i]) raw_hist[i] = 0;
            steer_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (steer_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result raw=%0d smooth=%0d",
                                 i_raw_steering, i_smoothed_steering);
                end else begin
                    exp_r = steer_q.pop_front();
                    if (exp_r.raw !== i_raw_steering ||
                        exp_r.smooth !== i_smoothed_steering) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch raw exp %0d got %0d, smooth exp %0d got %0d",
                                     exp_r.raw, i_raw_steering,
                                     exp_r.smooth, i_smoothed_steering);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_steer(longint'(i_lateral_error), longint'(i_heading_error));
            if (i_cfg_we) begin
                case (fsc_pkg::t_cfg_idx'(i_cfg_index))
                    fsc_pkg::CFG_LAT_LEFT:
                        bp_lat[0] = longint'($signed(i_cfg_data[15:0]));
                    fsc_pkg::CFG_LAT_CENTER:
                        bp_lat[1] = longint'($signed(i_cfg_data[15:0]));
                    fsc_pkg::CFG_LAT_RIGHT:
                        bp_lat[2] = longint'($signed(i_cfg_data[15:0]));
                    fsc_pkg::CFG_HEAD_LEFT:
                        bp_head[0] = longint'($signed(i_cfg_data));
                    fsc_pkg::CFG_HEAD_CENTER:
                        bp_head[1] = longint'($signed(i_cfg_data));
                    fsc_pkg::CFG_HEAD_RIGHT:
                        bp_head[2] = longint'($signed(i_cfg_data));
                    fsc_pkg::CFG_STEER_RIGHT:
                        lim_right = longint'($signed(i_cfg_data[14:0]));
                    fsc_pkg::CFG_STEER_LEFT:
                        lim_left = longint'($signed(i_cfg_data[14:0]));
                    default: ;
                endcase
            end
        end
        o_pending = steer_q.size();
    end
endmodule

// ===== tb/fuzzy_steering_controller_top_tb.sv =====
// Testbench top for the fuzzy steering controller: clock, reset, stimulus,
// config phases and verdict. Depends on fsc_pkg, fsc_checker and the DUT.
module fuzzy_steering_controller_top_tb;

    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk, i_rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [fsc_pkg::LAT_W-1:0] lat_err;
    logic signed [fsc_pkg::HEAD_W-1:0] head_err;
    logic signed [fsc_pkg::STEER_W-1:0] raw_steer, smooth_steer;
    logic cfg_we;
    logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fsc_pkg::CFG_W-1:0] cfg_data;
    int fail_count, pending, cycles;

    // Current breakpoints, tracked so stimulus can aim at the membership regions
    int lat_bp [3];
    int head_bp [3];

    fuzzy_steering_controller_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_lateral_error(lat_err), .i_heading_error(head_err),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_raw_steering(raw_steer), .o_smoothed_steering(smooth_steer),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    fsc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_lateral_error(lat_err), .i_heading_error(head_err),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_raw_steering(raw_steer), .i_smoothed_steering(smooth_steer),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("fuzzy_steering_controller_top verification failed");
            $finish;
        end
    end

    // Receiver stall pattern: alternate free-running stretches with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if ((cycles / 500) % 3 == 0) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) < 60);
        end
    end

    task automatic write_reg(input fsc_pkg::t_cfg_idx idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= fsc_pkg::CFG_W'(value);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the item until the transfer happens, then for a nonzero gap drop valid and idle for the gap
    task automatic send_item(input int lat, input int head, input int gap);
        in_valid <= 1'b1;
        lat_err <= fsc_pkg::LAT_W'(lat);
        head_err <= fsc_pkg::HEAD_W'(head);
        do @(posedge i_clk); while (!(in_valid && in_ready));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain every expected transfer, then let the block settle before config
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_breakpoints(input int l1, l2, l3, h1, h2, h3, input int r, lft);
        write_reg(fsc_pkg::CFG_LAT_LEFT, l1);
        write_reg(fsc_pkg::CFG_LAT_CENTER, l2);
        write_reg(fsc_pkg::CFG_LAT_RIGHT, l3);
        write_reg(fsc_pkg::CFG_HEAD_LEFT, h1);
        write_reg(fsc_pkg::CFG_HEAD_CENTER, h2);
        write_reg(fsc_pkg::CFG_HEAD_RIGHT, h3);
        write_reg(fsc_pkg::CFG_STEER_RIGHT, r);
        write_reg(fsc_pkg::CFG_STEER_LEFT, lft);
        lat_bp = '{l1, l2, l3};
        head_bp = '{h1, h2, h3};
    endtask

    // Pick a value near the breakpoints most of the time, else an end of the range or anywhere
    function automatic int pick_near(input int bp [3], input int lo, input int hi);
        int v, k;
        k = $urandom_range(0, 9);
        if (k < 7) begin
            v = bp[$urandom_range(0, 2)] + $signed($urandom_range(0, 1600)) - 800;
        end else if (k == 7) begin
            v = (k % 2) ? lo : hi;
            v = $urandom_range(0, 1) ? lo : hi;
        end else begin
            v = lo + int'($urandom_range(0, hi - lo));
        end
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    task automatic random_phase(input int count);
        int burst, gap;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = $urandom_range(1, 30);
            end
            burst--;
            send_item(pick_near(lat_bp, -32768, 32767), pick_near(head_bp, -65536, 65535),
                      (burst == 0) ? gap : 0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        lat_err = '0;
        head_err = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        lat_bp = '{-384, 0, 384};
        head_bp = '{-5120, 0, 5120};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every rule region and both full limits at reset values
        send_item(-32768, -65536, 0);
        send_item(32767, 65535, 0);
        send_item(-32768, 65535, 3);
        send_item(32767, -65536, 0);
        send_item(-100, -1000, 0);
        send_item(-200, 3000, 0);
        send_item(200, -3000, 1);
        send_item(100, 1000, 0);
        send_item(0, 0, 0);
        send_item(-384, 0, 0);
        send_item(384, 0, 0);
        send_item(0, 5120, 2);
        send_item(0, -5120, 0);
        send_item(-1, 1, 0);
        send_item(1, -1, 0);
        send_item(-21845, 43690, 0);
        send_item(21845, -43691, 0);
        random_phase(300);
        drain();

        // Extreme breakpoints and limits that saturate
        set_breakpoints(-32768, 0, 32767, -65536, 0, 65535, 16383, -16384);
        random_phase(300);
        drain();

        // Narrow spans and swapped-sign limits
        set_breakpoints(-2, -1, 1, 10, 11, 13, -16384, 16383);
        random_phase(250);
        drain();

        // Unordered breakpoints: zero-weight and no-rule cases
        set_breakpoints(500, 0, -500, 4000, 0, -4000, 1234, -4321);
        send_item(0, 0, 0);
        send_item(200, 200, 0);
        send_item(-200, -200, 0);
        random_phase(250);
        drain();

        set_breakpoints(-1000, 300, 400, -20000, -100, 30000, 8640, -8640);
        random_phase(300);
        drain();

        // Restore the reset set
        set_breakpoints(-384, 0, 384, -5120, 0, 5120, 8640, -8640);
        random_phase(350);
        drain();

        if (fail_count == 0) begin
            $display("fuzzy_steering_controller_top verification clean");
        end else begin
            $display("fuzzy_steering_controller_top verification failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/fsc_pkg.sv
sv/fsc_div.sv
sv/fsc_mac.sv
sv/fuzzy_steering_controller_top.sv
sv/fsc_checker.sv
tb/fsc_checker.sv
tb/fuzzy_steering_controller_top_tb.sv
